// ===== sv/plp_pkg.sv =====
// Package for the properties line parser.
// Holds the byte codes it recognizes, the result kind codes and the result record.
// No dependencies.
package plp_pkg;

  // Byte codes the parser reacts to.
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChSpace     = 8'd32;
  localparam logic [7:0] ChTab       = 8'd9;
  localparam logic [7:0] ChFormFeed  = 8'd12;
  localparam logic [7:0] ChCr        = 8'd13;
  localparam logic [7:0] ChHash      = 8'd35;
  localparam logic [7:0] ChBang      = 8'd33;
  localparam logic [7:0] ChBackslash = 8'd92;
  localparam logic [7:0] ChEquals    = 8'd61;
  localparam logic [7:0] ChColon     = 8'd58;
  localparam logic [7:0] ChLowerT    = 8'd116;
  localparam logic [7:0] ChLowerR    = 8'd114;
  localparam logic [7:0] ChLowerN    = 8'd110;
  localparam logic [7:0] ChLowerF    = 8'd102;

  // What a result item carries.
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_END_KEY  = 2'd2,
    KIND_END_PAIR = 2'd3
  } kind_t;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } res_t;

  // Whitespace skipped at line start and between key and value.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChFormFeed);
  endfunction

  // Key/value separator.
  function automatic logic is_sep(input logic [7:0] b);
    return (b == ChEquals) || (b == ChColon);
  endfunction

  // Decode the byte that follows a backslash.
  function automatic logic [7:0] decode_escaped(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == ChLowerT) begin
      r = ChTab;
    end else if (b == ChLowerR) begin
      r = ChCr;
    end else if (b == ChLowerN) begin
      r = ChNewline;
    end else if (b == ChLowerF) begin
      r = ChFormFeed;
    end
    return r;
  endfunction

endpackage

// ===== sv/properties_line_parser.sv =====
// Properties line parser: one text byte in, up to two tagged key/value items out.
// Results are registered in the result queue and leave it in arrival order.
// Throughput: one input item per cycle while the queue holds at most one entry;
// an item can cause two results, and a three-entry queue decouples the two sides.
// Reset: synchronous, active-low rst_n empties the queue and returns to line start.
// Depends on plp_pkg.
module properties_line_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] end_of_stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output plp_pkg::kind_t       out_tuser,  // [1:0] out_kind
  output logic                 out_tlast   // last_of_run
);
  import plp_pkg::*;

  typedef enum logic [2:0] {
    PM_LINE_START = 3'd0,
    PM_COMMENT    = 3'd1,
    PM_KEY        = 3'd2,
    PM_PRE_VALUE  = 3'd3,
    PM_VALUE      = 3'd4,
    PM_JOIN       = 3'd5
  } mode_t;

  localparam int Depth = 3;

  mode_t      parse_mode_r, parse_mode_nxt;
  mode_t      resume_mode_r, resume_mode_nxt;
  logic       bp_r, bp_nxt;
  logic       sep_r, sep_nxt;

  res_t       q_r [Depth];
  res_t       q_nxt [Depth];
  logic [1:0] cnt_r, cnt_nxt;

  logic       in_fire, pop;
  logic [1:0] n_res;
  res_t       r0, r1;
  mode_t      eff_mode, close_mode;
  logic       do_close;
  logic [7:0] b;
  logic [1:0] base;
  logic [1:0] push_n;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (cnt_r <= 2'd1);
  assign pop       = out_tvalid && out_tready;
  assign b         = in_tdata;

  // Parse one item: next mode and up to two results.
  always_comb begin
    parse_mode_nxt  = parse_mode_r;
    resume_mode_nxt = resume_mode_r;
    bp_nxt          = bp_r;
    sep_nxt         = sep_r;
    n_res           = 2'd0;
    r0              = '{data: 8'd0, kind: KIND_KEY, last: 1'b0};
    r1              = '{data: 8'd0, kind: KIND_KEY, last: 1'b0};
    do_close        = 1'b0;
    close_mode      = parse_mode_r;
    eff_mode        = parse_mode_r;

    if (in_tuser) begin
      do_close   = 1'b1;
      close_mode = (parse_mode_r == PM_JOIN) ? resume_mode_r : parse_mode_r;
    end else if (bp_r) begin
      // Byte after an escaping backslash.
      bp_nxt = 1'b0;
      if (b == ChNewline) begin
        resume_mode_nxt = parse_mode_r;
        parse_mode_nxt  = PM_JOIN;
      end else if (parse_mode_r == PM_LINE_START || parse_mode_r == PM_KEY) begin
        n_res          = 2'd1;
        r0.data        = decode_escaped(b);
        r0.kind        = KIND_KEY;
        parse_mode_nxt = PM_KEY;
      end else begin
        n_res          = 2'd1;
        r0.data        = decode_escaped(b);
        r0.kind        = KIND_VALUE;
        parse_mode_nxt = PM_VALUE;
      end
    end else if (parse_mode_r == PM_JOIN && is_ws(b)) begin
      // Leading whitespace of a joined line is dropped.
    end else if (parse_mode_r == PM_JOIN && b == ChNewline) begin
      do_close   = 1'b1;
      close_mode = resume_mode_r;
    end else begin
      if (parse_mode_r == PM_JOIN) begin
        eff_mode = resume_mode_r;
      end
      parse_mode_nxt = eff_mode;
      unique case (eff_mode)
        PM_COMMENT: begin
          if (b == ChNewline) begin
            do_close   = 1'b1;
            close_mode = PM_COMMENT;
          end
        end
        PM_KEY: begin
          if (b == ChNewline) begin
            do_close   = 1'b1;
            close_mode = PM_KEY;
          end else if (b == ChBackslash) begin
            bp_nxt = 1'b1;
          end else if (is_sep(b) || is_ws(b)) begin
            n_res          = 2'd1;
            r0.kind        = KIND_END_KEY;
            sep_nxt        = is_sep(b);
            parse_mode_nxt = PM_PRE_VALUE;
          end else begin
            n_res   = 2'd1;
            r0.data = b;
            r0.kind = KIND_KEY;
          end
        end
        PM_PRE_VALUE: begin
          if (b == ChNewline) begin
            do_close   = 1'b1;
            close_mode = PM_PRE_VALUE;
          end else if (b == ChBackslash) begin
            bp_nxt = 1'b1;
          end else if (is_ws(b)) begin
            // Whitespace before the value is skipped.
          end else if (is_sep(b) && !sep_r) begin
            sep_nxt = 1'b1;
          end else begin
            n_res          = 2'd1;
            r0.data        = b;
            r0.kind        = KIND_VALUE;
            parse_mode_nxt = PM_VALUE;
          end
        end
        PM_VALUE: begin
          if (b == ChNewline) begin
            do_close   = 1'b1;
            close_mode = PM_VALUE;
          end else if (b == ChBackslash) begin
            bp_nxt = 1'b1;
          end else begin
            n_res   = 2'd1;
            r0.data = b;
            r0.kind = KIND_VALUE;
          end
        end
        default: begin
          // Line start.
          parse_mode_nxt = PM_LINE_START;
          if (is_ws(b) || b == ChNewline) begin
            sep_nxt = 1'b0;
          end else if (b == ChHash || b == ChBang) begin
            parse_mode_nxt = PM_COMMENT;
          end else if (b == ChBackslash) begin
            bp_nxt = 1'b1;
          end else if (is_sep(b)) begin
            n_res          = 2'd1;
            r0.kind        = KIND_END_KEY;
            sep_nxt        = 1'b1;
            parse_mode_nxt = PM_PRE_VALUE;
          end else begin
            n_res          = 2'd1;
            r0.data        = b;
            r0.kind        = KIND_KEY;
            parse_mode_nxt = PM_KEY;
          end
        end
      endcase
    end

    // Closing a logical line emits its trailing markers and resets the mode.
    if (do_close) begin
      if (close_mode == PM_KEY) begin
        n_res   = 2'd2;
        r0.kind = KIND_END_KEY;
        r1.kind = KIND_END_PAIR;
      end else if (close_mode == PM_PRE_VALUE || close_mode == PM_VALUE) begin
        n_res   = 2'd1;
        r0.kind = KIND_END_PAIR;
      end
      parse_mode_nxt  = PM_LINE_START;
      resume_mode_nxt = PM_LINE_START;
      sep_nxt         = 1'b0;
      bp_nxt          = 1'b0;
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // Result queue: pop from the head, then append new items behind what is left.
  assign push_n = in_fire ? n_res : 2'd0;
  assign base   = cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    // Entries at or above base are free, so new results may land there.
    for (int i = 0; i < Depth; i++) begin
      if (3'(i) == {1'b0, base}) begin
        q_nxt[i] = r0;
      end else if (3'(i) == {1'b0, base} + 3'd1) begin
        q_nxt[i] = r1;
      end
    end
    cnt_nxt = base + push_n;
  end

  // Parser state and queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_mode_r  <= PM_LINE_START;
      resume_mode_r <= PM_LINE_START;
      bp_r          <= 1'b0;
      sep_r         <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (in_fire) begin
        parse_mode_r  <= parse_mode_nxt;
        resume_mode_r <= resume_mode_nxt;
        bp_r          <= bp_nxt;
        sep_r         <= sep_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[0].data;
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

`ifndef SYNTHESIS
  // End of stream always leaves the parser at line start with no escape pending.
  a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> parse_mode_r == PM_LINE_START && !bp_r)
    else $error("end of stream did not return the parser to line start");

  // An end-of-pair marker is always the last result of its item.
  a_end_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END_PAIR |-> out_tlast)
    else $error("end of pair without last flag");

  // An escape is only pending in a mode that can take an escaped byte.
  a_bp_mode: assert property (@(posedge clk) disable iff (!rst_n)
    bp_r |-> parse_mode_r != PM_COMMENT && parse_mode_r != PM_JOIN)
    else $error("escape pending in comment or join mode");
`endif

endmodule

// ===== test/plp_checker.sv =====
`timescale 1ns / 100ps
// Checker for the properties line parser: watches both streams, predicts the tagged
// key/value items from each accepted text byte, and compares them in order.
// Depends on plp_pkg.
module plp_checker
  import plp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] end_of_stream
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [7:0] out_byte
  input  kind_t      out_tuser,   // [1:0] out_kind
  input  logic       out_tlast,   // last_of_run
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  localparam int MaxReports = 20;

  // Where the parser stands within the current logical line.
  typedef enum logic [2:0] {
    LS_START,
    LS_COMMENT,
    LS_KEY,
    LS_PRE_VALUE,
    LS_VALUE,
    LS_JOIN
  } line_state_t;

  line_state_t line_state;
  line_state_t join_resume;
  logic        escape_open;
  logic        sep_taken;
  res_t        expected_tokens[$];

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChFormFeed);
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    return (b == ChEquals) || (b == ChColon);
  endfunction

  // Byte that an escape sequence stands for.
  function automatic logic [7:0] unescape(input logic [7:0] b);
    case (b)
      ChLowerT: return ChTab;
      ChLowerR: return ChCr;
      ChLowerN: return ChNewline;
      ChLowerF: return ChFormFeed;
      default:  return b;
    endcase
  endfunction

  task automatic emit(input logic [7:0] b, input kind_t k);
    res_t r;
    r.data = b;
    r.kind = k;
    r.last = 1'b0;
    expected_tokens.push_back(r);
  endtask

  // Ends the logical line; the markers depend on how far the line got.
  task automatic close_line(input line_state_t st);
    if (st == LS_KEY) begin
      emit(8'd0, KIND_END_KEY);
      emit(8'd0, KIND_END_PAIR);
    end else if (st == LS_PRE_VALUE || st == LS_VALUE) begin
      emit(8'd0, KIND_END_PAIR);
    end
    line_state  = LS_START;
    join_resume = LS_START;
    sep_taken   = 1'b0;
    escape_open = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    // The byte after a backslash is either a line join or a literal character.
    if (escape_open) begin
      escape_open = 1'b0;
      if (b == ChNewline) begin
        join_resume = line_state;
        line_state  = LS_JOIN;
      end else if (line_state == LS_START || line_state == LS_KEY) begin
        emit(unescape(b), KIND_KEY);
        line_state = LS_KEY;
      end else begin
        emit(unescape(b), KIND_VALUE);
        line_state = LS_VALUE;
      end
      return;
    end

    // A joined line drops its leading whitespace; an empty one ends the line.
    if (line_state == LS_JOIN) begin
      if (is_blank(b)) return;
      if (b == ChNewline) begin
        close_line(join_resume);
        return;
      end
      line_state = join_resume;
    end

    case (line_state)
      LS_COMMENT: begin
        if (b == ChNewline) close_line(LS_COMMENT);
      end
      LS_KEY: begin
        if (b == ChNewline) begin
          close_line(LS_KEY);
        end else if (b == ChBackslash) begin
          escape_open = 1'b1;
        end else if (is_separator(b) || is_blank(b)) begin
          emit(8'd0, KIND_END_KEY);
          sep_taken  = is_separator(b);
          line_state = LS_PRE_VALUE;
        end else begin
          emit(b, KIND_KEY);
        end
      end
      LS_PRE_VALUE: begin
        if (b == ChNewline) begin
          close_line(LS_PRE_VALUE);
        end else if (b == ChBackslash) begin
          escape_open = 1'b1;
        end else if (is_blank(b)) begin
          // Whitespace between key and value is dropped.
        end else if (is_separator(b) && !sep_taken) begin
          sep_taken = 1'b1;
        end else begin
          emit(b, KIND_VALUE);
          line_state = LS_VALUE;
        end
      end
      LS_VALUE: begin
        if (b == ChNewline) begin
          close_line(LS_VALUE);
        end else if (b == ChBackslash) begin
          escape_open = 1'b1;
        end else begin
          emit(b, KIND_VALUE);
        end
      end
      default: begin
        line_state = LS_START;
        if (is_blank(b) || b == ChNewline) begin
          sep_taken = 1'b0;
        end else if (b == ChHash || b == ChBang) begin
          line_state = LS_COMMENT;
        end else if (b == ChBackslash) begin
          escape_open = 1'b1;
        end else if (is_separator(b)) begin
          emit(8'd0, KIND_END_KEY);
          sep_taken  = 1'b1;
          line_state = LS_PRE_VALUE;
        end else begin
          emit(b, KIND_KEY);
          line_state = LS_KEY;
        end
      end
    endcase
  endtask

  // Predicts all items caused by one input item and marks the last of them.
  task automatic predict_item(input logic [7:0] b, input logic eos);
    int   before_n;
    res_t tail;
    before_n = expected_tokens.size();
    if (eos) begin
      close_line((line_state == LS_JOIN) ? join_resume : line_state);
    end else begin
      parse_byte(b);
    end
    if (expected_tokens.size() > before_n) begin
      tail = expected_tokens.pop_back();
      tail.last = 1'b1;
      expected_tokens.push_back(tail);
    end
  endtask

  // Compare each result item first, then predict from the input item of the same edge.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      line_state   = LS_START;
      join_resume  = LS_START;
      escape_open  = 1'b0;
      sep_taken    = 1'b0;
      expected_tokens.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_tokens.size() == 0) begin
          if (fail_count < MaxReports) begin
            $display("%0t ERROR: unexpected item byte=%02h kind=%0d last=%b",
                     $time, out_tdata, out_tuser, out_tlast);
          end
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_tdata !== want.data || out_tuser !== want.kind ||
              out_tlast !== want.last) begin
            if (fail_count < MaxReports) begin
              $display("%0t ERROR: expected byte=%02h kind=%0d last=%b, got byte=%02h kind=%0d last=%b",
                       $time, want.data, want.kind, want.last,
                       out_tdata, out_tuser, out_tlast);
            end
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser);
    end
    pending = expected_tokens.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the properties line parser testbench: clock, reset, text stimulus with
// random idling on both streams, a watchdog and the verdict.
// Depends on plp_pkg, properties_line_parser and plp_checker.
module tb;
  import plp_pkg::*;

  localparam int RandomItems   = 1200;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 8;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] data_byte
  logic       in_tuser;    // [0] end_of_stream
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] out_byte
  kind_t      out_tuser;   // [1:0] out_kind
  logic       out_tlast;   // last_of_run

  int fail_count;
  int pending;
  int results_seen;

  int unsigned items_sent;
  int unsigned eos_sent;
  int          stall_cycles;
  bit          send_idle;
  bit          recv_idle;
  bit          hold_req;
  logic [8:0]  text_q[$];   // bit 8 marks an end-of-stream item

  properties_line_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  plp_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: ends the run if neither stream moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, stall_cycles);
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random stalls per item, plus one long hold-off on request.
  initial begin
    int  wait_n;
    bit  hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      wait_n = recv_idle ? $urandom_range(0, 8) : 0;
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offers one input item after a random gap and holds it until accepted.
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (eos) eos_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i][7:0], text_q[i][8]);
    text_q.delete();
  endtask

  task automatic push_byte(input logic [7:0] b);
    text_q.push_back({1'b0, b});
  endtask

  // The data byte of an end-of-stream item is ignored, so it is random.
  task automatic push_eos();
    text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic push_blanks(input int n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       push_byte(ChSpace);
        1:       push_byte(ChTab);
        default: push_byte(ChFormFeed);
      endcase
    end
  endtask

  // Random byte that keeps a key or value well formed.
  function automatic logic [7:0] plain_char(input bit in_key, input bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == ChNewline || c == ChBackslash ||
               (in_key && (c == ChSpace || c == ChTab || c == ChFormFeed ||
                           c == ChEquals || c == ChColon)) ||
               (first && (c == ChHash || c == ChBang)));
    return c;
  endfunction

  task automatic push_escape();
    push_byte(ChBackslash);
    case ($urandom_range(0, 9))
      0:       push_byte(ChLowerT);
      1:       push_byte(ChLowerR);
      2:       push_byte(ChLowerN);
      3:       push_byte(ChLowerF);
      4:       push_byte(ChEquals);
      5:       push_byte(ChColon);
      6:       push_byte(ChSpace);
      7:       push_byte(ChBackslash);
      8:       push_byte(ChHash);
      default: push_byte(plain_char(1'b0, 1'b0));
    endcase
  endtask

  // Backslash-newline followed by the next line's indent.
  task automatic push_join();
    push_byte(ChBackslash);
    push_byte(ChNewline);
    push_blanks($urandom_range(0, 3));
  endtask

  // A key/value line with random content, escapes and line joins.
  task automatic build_pair();
    int nkey;
    int nval;
    int pick;
    push_blanks($urandom_range(0, 2));
    nkey = $urandom_range(0, 6);
    for (int i = 0; i < nkey; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) push_escape();
      else if (pick < 20 && i > 0) push_join();
      else push_byte(plain_char(1'b1, i == 0));
    end
    push_blanks($urandom_range(0, 2));
    if (nkey == 0 || $urandom_range(0, 9) < 7) begin
      push_byte(($urandom_range(0, 1) != 0) ? ChEquals : ChColon);
    end
    if ($urandom_range(0, 9) == 0) push_join();
    push_blanks($urandom_range(0, 2));
    nval = $urandom_range(0, 8);
    for (int i = 0; i < nval; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) push_escape();
      else if (pick < 20) push_join();
      else if (pick < 25) push_byte(ChEquals);
      else if (pick < 30) push_byte(ChSpace);
      else push_byte(plain_char(1'b0, 1'b0));
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      push_eos();
    end else if (pick < 10) begin
      push_join();
      push_byte(ChNewline);
    end else begin
      push_byte(ChNewline);
    end
  endtask

  task automatic build_comment();
    push_blanks($urandom_range(0, 2));
    push_byte(($urandom_range(0, 1) != 0) ? ChHash : ChBang);
    repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)) | 8'h80);
    if ($urandom_range(0, 3) == 0) push_byte(ChBackslash);
    push_byte(ChNewline);
  endtask

  task automatic build_blank();
    push_blanks($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) push_eos();
    else push_byte(ChNewline);
  endtask

  // Unstructured bytes, weighted toward the characters the parser reacts to.
  task automatic build_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 19) == 0) begin
        push_eos();
      end else if ($urandom_range(0, 1) != 0) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 9))
          0:       push_byte(ChNewline);
          1:       push_byte(ChSpace);
          2:       push_byte(ChTab);
          3:       push_byte(ChFormFeed);
          4:       push_byte(ChCr);
          5:       push_byte(ChHash);
          6:       push_byte(ChBang);
          7:       push_byte(ChBackslash);
          8:       push_byte(ChEquals);
          default: push_byte(ChColon);
        endcase
      end
    end
  endtask

  // Lets every expected item drain with the input stream quiet.
  task automatic drain_pause();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned phase;
    int unsigned target;
    int          sel;
    bit          paused;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tuser   = 1'b0;
    items_sent = 0;
    eos_sent   = 0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    hold_req   = 1'b0;
    paused     = 1'b0;
    phase      = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Tab skipped, empty key, value byte 0xFF, line end after the value.
    push_byte(ChTab); push_byte(ChEquals); push_byte(8'hFF); push_byte(ChNewline);
    // Key byte 0x00, escaped tab in the key, colon, line end right after the colon.
    push_byte(8'h00); push_byte(ChBackslash); push_byte(ChLowerT);
    push_byte(ChColon); push_byte(ChNewline);
    // Both comment markers, and a line of only whitespace.
    push_byte(ChHash); push_byte(ChNewline);
    push_byte(ChBang); push_byte(ChNewline);
    push_byte(ChFormFeed); push_byte(ChNewline);
    // Join at line start, key ended by a space, join before the value,
    // then an empty joined line that ends the pair.
    push_byte(ChBackslash); push_byte(ChNewline); push_byte(ChSpace);
    push_byte(8'h61); push_byte(ChSpace); push_byte(ChBackslash);
    push_byte(ChNewline); push_byte(ChNewline);
    // Stream end inside a key closes both the key and the pair.
    push_byte(8'h62); push_eos();
    send_text();

    target = items_sent + RandomItems;
    while (items_sent < target) begin
      // Idle behavior changes every 150 items, including idle-free stretches.
      if (items_sent / 150 != phase) begin
        phase     = items_sent / 150;
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (items_sent >= 400) hold_req = 1'b1;
      if (!paused && items_sent >= 800) begin
        paused = 1'b1;
        drain_pause();
      end
      sel = $urandom_range(0, 99);
      if (sel < 62) build_pair();
      else if (sel < 72) build_comment();
      else if (sel < 80) build_blank();
      else build_noise();
      send_text();
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    $display("Summary: %0d input items (%0d stream ends) driven, %0d result items checked.",
             items_sent, eos_sent, results_seen);
    $display("Covered: directed corner lines, random pairs, comments, joins and noise, %s",
             "a long output hold-off and a full drain pause.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
